[hdl/bdi_pkg.sv]
// bdi_pkg: shared types and constants for the bounded deque with insert
// depends on nothing; used by bdi_cell, bounded_deque_with_insert, bdi_checker and tb
`timescale 1ns / 1ps

package bdi_pkg;

  // default sizes of the store
  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // request and result field widths
  localparam int OPCODE_W   = 3;
  localparam int VALUE_W    = 32;
  localparam int POSITION_W = 8;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 5;

  // packed stream widths, rounded up to whole bytes
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 72;

  // request opcodes
  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_INSERT     = 3'd4
  } opcode_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // per-cycle action broadcast along the cell row
  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_INSERT    = 2'd1,
    CELL_POP_FRONT = 2'd2
  } cell_op_t;

endpackage

[hdl/bdi_cell.sv]
// bdi_cell: one storage slot of the deque row
// depends on bdi_pkg; instantiated in a row by bounded_deque_with_insert
`timescale 1ns / 1ps

module bdi_cell #(
  parameter int DATA_WIDTH = bdi_pkg::DATA_WIDTH_DEF,
  parameter int CNT_W      = 5,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  bdi_pkg::cell_op_t     kind,
  input  logic [CNT_W-1:0]      pos,
  input  logic [DATA_WIDTH-1:0] load_value,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic [CNT_W-1:0]      count,
  output logic [DATA_WIDTH-1:0] data,
  output logic [DATA_WIDTH-1:0] tail_tap
);

  localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] MY_LAST = CNT_W'(IDX + 1);

  // slot update: load, take from the front neighbor, take from the back neighbor
  always_ff @(posedge clk) begin
    case (kind)
      bdi_pkg::CELL_INSERT: begin
        if (MY_IDX == pos) begin
          data <= load_value;
        end else if (MY_IDX > pos) begin
          data <= left_data;
        end
      end
      bdi_pkg::CELL_POP_FRONT: begin
        data <= right_data;
      end
      default: begin
      end
    endcase
  end

  // present the value only when this slot holds the last element
  assign tail_tap = (MY_LAST == count) ? data : '0;

endmodule

[hdl/bounded_deque_with_insert.sv]
// bounded_deque_with_insert: ordered store as a row of shifting cells (bdi_pkg, bdi_cell)
// Result path: the cells, count and pending status update at the accepting edge; the result
// register loads from them once it is empty or its result is being taken.
// Throughput: one request per cycle while results are taken; a request stalls only while
// a result waits in the output register and another one is pending behind it.
// Reset: synchronous active-high rst empties the store and drops pending results.
`timescale 1ns / 1ps

module bounded_deque_with_insert #(
  parameter int CAPACITY   = bdi_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = bdi_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // opcode[2:0], value[34:3], position[42:35], zero fill above
  input  logic [bdi_pkg::S_DATA_W-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // status[1:0], front_value[33:2], back_value[65:34], is_empty[66],
  // element_count[71:67]
  output logic [bdi_pkg::M_DATA_W-1:0]  m_tdata
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

  // request fields
  logic [bdi_pkg::OPCODE_W-1:0]   opcode;
  logic [bdi_pkg::VALUE_W-1:0]    value;
  logic [bdi_pkg::POSITION_W-1:0] position;

  assign opcode   = s_tdata[2:0];
  assign value    = s_tdata[34:3];
  assign position = s_tdata[42:35];

  // state
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic                   pend;
  bdi_pkg::status_t       pend_status;
  bdi_pkg::status_t       status_next;

  // cell row control
  bdi_pkg::cell_op_t      kind;
  logic [CNT_W-1:0]       ins_pos;
  logic [DATA_WIDTH-1:0]  load_value;

  // handshake
  logic                   accept;
  logic                   load_out;

  assign load_out = pend && (!m_tvalid || m_tready);
  assign s_tready = !pend || load_out;
  assign accept   = s_tvalid && s_tready;

  // width adaptation of value and position
  logic [DATA_WIDTH+bdi_pkg::VALUE_W-1:0]  value_ext;
  logic [CNT_W+bdi_pkg::POSITION_W-1:0]    pos_ext;
  logic [CNT_W+bdi_pkg::POSITION_W-1:0]    count_ext;

  assign value_ext  = {{DATA_WIDTH{1'b0}}, value};
  assign load_value = value_ext[DATA_WIDTH-1:0];
  assign pos_ext    = {{CNT_W{1'b0}}, position};
  assign count_ext  = {{bdi_pkg::POSITION_W{1'b0}}, count};

  // decode the request into a row action, new count and status
  always_comb begin
    logic is_full;
    logic is_zero;
    is_full     = (count == FULL_COUNT);
    is_zero     = (count == '0);
    kind        = bdi_pkg::CELL_HOLD;
    ins_pos     = '0;
    count_next  = count;
    status_next = bdi_pkg::ST_DONE;
    unique case (opcode) inside
      bdi_pkg::OP_PUSH_FRONT, bdi_pkg::OP_PUSH_BACK, bdi_pkg::OP_INSERT: begin
        if (is_full) begin
          status_next = bdi_pkg::ST_FULL;
        end else if (opcode == bdi_pkg::OP_INSERT && pos_ext > count_ext) begin
          status_next = bdi_pkg::ST_BADPOS;
        end else begin
          kind       = bdi_pkg::CELL_INSERT;
          count_next = count + 1'b1;
          if (opcode == bdi_pkg::OP_PUSH_FRONT) begin
            ins_pos = '0;
          end else if (opcode == bdi_pkg::OP_PUSH_BACK) begin
            ins_pos = count;
          end else begin
            ins_pos = pos_ext[CNT_W-1:0];
          end
        end
      end
      bdi_pkg::OP_POP_FRONT: begin
        if (is_zero) begin
          status_next = bdi_pkg::ST_EMPTY;
        end else begin
          kind       = bdi_pkg::CELL_POP_FRONT;
          count_next = count - 1'b1;
        end
      end
      bdi_pkg::OP_POP_BACK: begin
        if (is_zero) begin
          status_next = bdi_pkg::ST_EMPTY;
        end else begin
          count_next = count - 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (!accept) begin
      kind = bdi_pkg::CELL_HOLD;
    end
  end

  // the cell row
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_tap  [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data;
    logic [DATA_WIDTH-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = cell_data[i];
    end else begin : g_inner_l
      assign left_data = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_inner_r
      assign right_data = cell_data[i+1];
    end

    bdi_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .kind       (kind),
      .pos        (ins_pos),
      .load_value (load_value),
      .left_data  (left_data),
      .right_data (right_data),
      .count      (count),
      .data       (cell_data[i]),
      .tail_tap   (cell_tap[i])
    );
  end

  // count and pending request
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pend  <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      if (accept) begin
        pend <= 1'b1;
      end else if (load_out) begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= status_next;
    end
  end

  // front and back of the settled row
  logic [DATA_WIDTH-1:0]                back_data;
  logic [DATA_WIDTH-1:0]                front_data;
  logic [DATA_WIDTH+bdi_pkg::VALUE_W-1:0] front_ext;
  logic [DATA_WIDTH+bdi_pkg::VALUE_W-1:0] back_ext;
  logic [CNT_W+bdi_pkg::COUNT_W-1:0]    cnt_out_ext;
  logic                                 empty_now;

  always_comb begin
    back_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      back_data = back_data | cell_tap[i];
    end
  end

  assign empty_now   = (count == '0);
  assign front_data  = empty_now ? '0 : cell_data[0];
  assign front_ext   = {{bdi_pkg::VALUE_W{1'b0}}, front_data};
  assign back_ext    = {{bdi_pkg::VALUE_W{1'b0}}, back_data};
  assign cnt_out_ext = {{bdi_pkg::COUNT_W{1'b0}}, count};

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {cnt_out_ext[bdi_pkg::COUNT_W-1:0],
                  empty_now,
                  back_ext[bdi_pkg::VALUE_W-1:0],
                  front_ext[bdi_pkg::VALUE_W-1:0],
                  pend_status};
    end
  end

endmodule

[test/bdi_checker.sv]
// bdi_checker: watches the request and result streams of bounded_deque_with_insert,
// predicts every result from its own copy of the store and compares field by field
// depends on bdi_pkg
`timescale 1ns / 1ps

module bdi_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  // opcode[2:0], value[34:3], position[42:35], zero fill above
  input  logic [bdi_pkg::S_DATA_W-1:0]  s_tdata,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  // status[1:0], front_value[33:2], back_value[65:34], is_empty[66],
  // element_count[71:67]
  input  logic [bdi_pkg::M_DATA_W-1:0]  m_tdata,
  output int                            fail_count,
  output int                            pending
);

  localparam int DEPTH      = bdi_pkg::CAPACITY_DEF;
  localparam int DW         = bdi_pkg::DATA_WIDTH_DEF;
  localparam int OPCODE_W   = bdi_pkg::OPCODE_W;
  localparam int VALUE_W    = bdi_pkg::VALUE_W;
  localparam int POSITION_W = bdi_pkg::POSITION_W;
  localparam int COUNT_W    = bdi_pkg::COUNT_W;

  typedef struct packed {
    bdi_pkg::status_t     status;
    logic [VALUE_W-1:0]   front;
    logic [VALUE_W-1:0]   back;
    logic                 empty;
    logic [COUNT_W-1:0]   count;
  } deque_result_t;

  // predicted contents of the store, front element in slot 0
  logic [DW-1:0]  slots [DEPTH];
  int unsigned    held;
  deque_result_t  expected_q [$];
  int             fail_tally;

  // apply one request to the predicted store and return the result it yields
  function automatic deque_result_t apply_request(input logic [OPCODE_W-1:0] op,
                                                  input logic [VALUE_W-1:0] val,
                                                  input logic [POSITION_W-1:0] pos);
    deque_result_t    r;
    bdi_pkg::status_t st;
    int unsigned      at;
    int unsigned      i;
    st = bdi_pkg::ST_DONE;
    at = 0;
    case (op) inside
      bdi_pkg::OP_PUSH_FRONT, bdi_pkg::OP_PUSH_BACK, bdi_pkg::OP_INSERT: begin
        // full is checked before the position
        if (held >= DEPTH) begin
          st = bdi_pkg::ST_FULL;
        end else begin
          if (op == bdi_pkg::OP_PUSH_BACK) at = held;
          else if (op == bdi_pkg::OP_INSERT) at = pos;
          if (at > held) begin
            st = bdi_pkg::ST_BADPOS;
          end else begin
            for (i = held; i > at; i--) slots[i] = slots[i-1];
            slots[at] = val[DW-1:0];
            held++;
          end
        end
      end
      bdi_pkg::OP_POP_FRONT: begin
        if (held == 0) begin
          st = bdi_pkg::ST_EMPTY;
        end else begin
          for (i = 0; i + 1 < held; i++) slots[i] = slots[i+1];
          held--;
        end
      end
      bdi_pkg::OP_POP_BACK: begin
        if (held == 0) st = bdi_pkg::ST_EMPTY;
        else held--;
      end
      // spare opcodes leave the store alone
      default: ;
    endcase
    r.status = st;
    r.empty  = (held == 0);
    r.front  = (held == 0) ? '0 : VALUE_W'(slots[0]);
    r.back   = (held == 0) ? '0 : VALUE_W'(slots[held-1]);
    r.count  = COUNT_W'(held);
    return r;
  endfunction

  // predict on each accepted request, compare on each accepted result
  always @(posedge clk) begin
    deque_result_t got;
    deque_result_t want;
    if (rst) begin
      held = 0;
      expected_q.delete();
    end else begin
      if (s_tvalid && s_tready)
        expected_q.insert(expected_q.size(),
                          apply_request(s_tdata[2:0], s_tdata[34:3], s_tdata[42:35]));
      if (m_tvalid && m_tready) begin
        got.status = bdi_pkg::status_t'(m_tdata[1:0]);
        got.front  = m_tdata[33:2];
        got.back   = m_tdata[65:34];
        got.empty  = m_tdata[66];
        got.count  = m_tdata[71:67];
        if (expected_q.size() == 0) begin
          fail_tally++;
          if (fail_tally <= 10)
            $display("%0t: result with no request pending: status=%0d count=%0d",
                     $time, got.status, got.count);
        end else begin
          want = expected_q[0];
          expected_q.delete(0);
          if (got.status !== want.status || got.front !== want.front ||
              got.back !== want.back || got.empty !== want.empty ||
              got.count !== want.count) begin
            fail_tally++;
            if (fail_tally <= 10) begin
              $display("%0t: mismatch exp status=%0d front=%h back=%h empty=%b count=%0d",
                       $time, want.status, want.front, want.back, want.empty, want.count);
              $display("%0t:          got status=%0d front=%h back=%h empty=%b count=%0d",
                       $time, got.status, got.front, got.back, got.empty, got.count);
            end
          end
        end
      end
    end
    pending    <= expected_q.size();
    fail_count <= fail_tally;
  end

endmodule

[test/tb.sv]
// tb: stimulus and verdict for bounded_deque_with_insert, directed requests first,
// then random request sequences under three idling phases
// depends on bdi_pkg, bounded_deque_with_insert and bdi_checker
`timescale 1ns / 1ps

module tb;

  localparam int OPCODE_W   = bdi_pkg::OPCODE_W;
  localparam int VALUE_W    = bdi_pkg::VALUE_W;
  localparam int POSITION_W = bdi_pkg::POSITION_W;

  // opcodes the block leaves unused
  localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;
  localparam int RANDOM_PER_PHASE = 400;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [bdi_pkg::S_DATA_W-1:0]  s_tdata = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [bdi_pkg::M_DATA_W-1:0]  m_tdata;
  int                            fail_count;
  int                            pending;
  int                            send_idle_pct = 29;
  int                            recv_idle_pct = 48;

  bounded_deque_with_insert i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  bdi_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side backpressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // drive one request and hold it until accepted, valid stays high for the next one
  task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] val,
                              input logic [POSITION_W-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, pos, val, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // random requests in segments that lean toward growing, churning or draining
  task automatic random_requests(input int count);
    int                    grow_pct;
    int                    seg_left;
    logic [OPCODE_W-1:0]   op;
    logic [VALUE_W-1:0]    val;
    logic [POSITION_W-1:0] pos;
    grow_pct = 50;
    seg_left = 0;
    repeat (count) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(60, 15);
        case ($urandom_range(2))
          0: grow_pct = 20;
          1: grow_pct = 50;
          default: grow_pct = 85;
        endcase
      end
      seg_left--;
      if ($urandom_range(99) < 3) begin
        op = OPCODE_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
      end else if ($urandom_range(99) < grow_pct) begin
        case ($urandom_range(2))
          0: op = bdi_pkg::OP_PUSH_FRONT;
          1: op = bdi_pkg::OP_PUSH_BACK;
          default: op = bdi_pkg::OP_INSERT;
        endcase
      end else begin
        op = $urandom_range(1) ? bdi_pkg::OP_POP_FRONT : bdi_pkg::OP_POP_BACK;
      end
      case ($urandom_range(9))
        0: val = '0;
        1: val = '1;
        default: val = $urandom;
      endcase
      // mostly positions near the fill level, now and then anywhere
      pos = ($urandom_range(9) == 0) ? POSITION_W'($urandom_range(255))
                                     : POSITION_W'($urandom_range(17));
      send_request(op, val, pos);
    end
  endtask

  // watchdog
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int k;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty store cases and popping the only element
    send_request(bdi_pkg::OP_POP_FRONT, '0, '0);
    send_request(bdi_pkg::OP_INSERT, '0, 8'd0);
    send_request(bdi_pkg::OP_POP_BACK, '0, '0);
    send_request(bdi_pkg::OP_INSERT, '1, 8'd0);
    send_request(bdi_pkg::OP_PUSH_BACK, '1, 8'd0);
    send_request(bdi_pkg::OP_PUSH_FRONT, '0, 8'hFF);
    // insert at the fill level appends, beyond it is refused
    send_request(bdi_pkg::OP_INSERT, 32'hA5A5_5A5A, 8'd3);
    send_request(bdi_pkg::OP_INSERT, 32'h1234_5678, 8'd5);
    send_request(bdi_pkg::OP_INSERT, 32'h1234_5678, 8'hFF);
    send_request(OP_SPARE_LO, 32'hDEAD_BEEF, 8'd1);
    send_request(OP_SPARE_HI, 32'hDEAD_BEEF, 8'd1);
    send_request(bdi_pkg::OP_POP_FRONT, '0, '0);
    // fill to capacity with a mix of pushes and inserts
    for (k = 0; k < 13; k++) begin
      case (k % 3)
        0: send_request(bdi_pkg::OP_PUSH_FRONT, $urandom, '0);
        1: send_request(bdi_pkg::OP_PUSH_BACK, $urandom, '0);
        default: send_request(bdi_pkg::OP_INSERT, $urandom, POSITION_W'(k / 2));
      endcase
    end
    // full store refuses pushes and inserts, even at a bad position
    send_request(bdi_pkg::OP_PUSH_BACK, 32'h0BAD_F00D, '0);
    send_request(bdi_pkg::OP_INSERT, 32'h0BAD_F00D, 8'hFF);

    // idling phases: receiver heavy, then sender heavy, then none
    random_requests(RANDOM_PER_PHASE);
    send_idle_pct = 48;
    recv_idle_pct = 29;
    random_requests(RANDOM_PER_PHASE);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_requests(RANDOM_PER_PHASE);
    s_tvalid <= 1'b0;

    // drain, then allow for stray results
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
